FILE: design/plw_pkg.sv
`timescale 1ns / 1ps

package plw_pkg;

  // Sizes settled by the item fields
  localparam int SAMPLE_W = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Default sizes of the internal counters
  localparam int COUNT_BITS_DEF = 48;
  localparam int TIME_BITS_DEF = 32;

  // Register reset values
  localparam logic [15:0] CHECK_INTERVAL_RST = 16'd5;
  localparam logic [7:0]  FAIL_LIMIT_RST     = 8'd3;
  localparam logic [15:0] COOLDOWN_TIME_RST  = 16'd60;
  localparam logic [7:0]  OFF_PAUSE_RST      = 8'd3;
  localparam logic [15:0] IDLE_TIME_RST      = 16'd0;

  localparam logic [7:0]  FAIL_MAX = 8'hFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHECK_INTERVAL = 3'd0,
    REG_FAIL_LIMIT     = 3'd1,
    REG_COOLDOWN_TIME  = 3'd2,
    REG_OFF_PAUSE      = 3'd3,
    REG_IDLE_TIME      = 3'd4,
    REG_SCOPE_SEL      = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    SCOPE_PROBE   = 2'd0,
    SCOPE_TRAFFIC = 2'd1,
    SCOPE_BOTH    = 2'd2,
    SCOPE_ALL     = 2'd3
  } scope_t;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_IDLE  = 2'd1,
    CAUSE_PROBE = 2'd2
  } cause_t;

  localparam scope_t SCOPE_SEL_RST = SCOPE_BOTH;

  typedef struct packed {
    logic                probe_ok;
    logic                count_ok;
    logic [SAMPLE_W-1:0] packet_count;
  } tick_in_t;

  typedef struct packed {
    logic        checked;
    logic        power_cycle;
    logic [1:0]  cause;
    logic [7:0]  failures;
    logic [15:0] cycle_total;
  } tick_out_t;

endpackage

FILE: design/port_liveness_watchdog_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  --------------------------------------
// in        input      in_valid/in_stall   tick_in_t: probe_ok, count_ok, packet_count
// out       output     out_valid/out_stall tick_out_t: checked, power_cycle, cause,
//                                          failures, cycle_total
// cfg       input      cfg_wr_en           cfg_index, cfg_data (no read-back)
//
// One tick per cycle while in_stall is low: an accepted tick is evaluated in its transfer
// cycle and its result enters the output register on that edge, or the skid when out is held.
// The path is three wrapped time subtracts, the idle-window compare and the packet compare.
// A skid register behind the result register keeps ticks flowing while one result
// waits; in_stall rises only when both hold a result.
// rst is synchronous: restore register defaults, clear timers, counts, baseline and entries.

module port_liveness_watchdog_unit import plw_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tick_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tick_out_t              out_data
);

  // Configuration registers
  logic [15:0] check_interval;
  logic [7:0]  fail_limit;
  logic [15:0] cooldown_time;
  logic [7:0]  off_pause;
  logic [15:0] idle_time;
  scope_t      scope_sel;

  // Watchdog state
  logic [TIME_BITS-1:0]  seconds_now;
  logic [TIME_BITS-1:0]  next_check_time, next_check_time_next;
  logic [TIME_BITS-1:0]  cooldown_end, cooldown_end_next;
  logic [7:0]            fail_counter, fail_counter_next;
  logic [15:0]           cycles_done_count, cycles_done_count_next;
  logic                  baseline_valid, baseline_valid_next;
  logic [COUNT_BITS-1:0] baseline_count, baseline_count_next;
  logic [TIME_BITS-1:0]  baseline_time, baseline_time_next;

  // Output entries
  tick_out_t skid_data;
  logic      skid_valid;
  tick_out_t result;

  logic                  in_xfer;
  logic                  out_free;
  logic [COUNT_BITS-1:0] sample;
  logic [TIME_BITS-1:0]  due_diff, cool_diff, idle_elapsed;
  logic                  due, cool_over;
  logic                  probe_watch, traffic_watch;
  logic                  idle_window;
  logic [7:0]            fail_bumped;
  logic                  idle_trip, probe_trip;
  logic [TIME_BITS-1:0]  cycle_end;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Take the sample modulo the baseline width
  assign sample = COUNT_BITS'(in_data.packet_count);

  // "Reached" means the wrapped difference has its top bit clear
  assign due_diff     = seconds_now - next_check_time;
  assign cool_diff    = seconds_now - cooldown_end;
  assign idle_elapsed = seconds_now - baseline_time;
  assign due          = !due_diff[TIME_BITS-1];
  assign cool_over    = !cool_diff[TIME_BITS-1];
  assign idle_window  = idle_elapsed >= TIME_BITS'(idle_time);

  assign probe_watch   = scope_sel != SCOPE_TRAFFIC;
  assign traffic_watch = scope_sel != SCOPE_PROBE;

  assign fail_bumped = (fail_counter == FAIL_MAX) ? fail_counter : fail_counter + 8'd1;
  assign cycle_end   = seconds_now + TIME_BITS'(off_pause) + TIME_BITS'(cooldown_time);

  // Triggers apply only when a check actually runs
  assign idle_trip = traffic_watch && (idle_time != 16'd0) && in_data.count_ok
                     && baseline_valid && idle_window && (sample <= baseline_count);
  assign probe_trip = probe_watch && !in_data.probe_ok && (fail_bumped >= fail_limit);

  // Per-tick evaluation
  always_comb begin
    next_check_time_next   = next_check_time;
    cooldown_end_next      = cooldown_end;
    fail_counter_next      = fail_counter;
    cycles_done_count_next = cycles_done_count;
    baseline_valid_next    = baseline_valid;
    baseline_count_next    = baseline_count;
    baseline_time_next     = baseline_time;
    result.checked         = 1'b0;
    result.power_cycle     = 1'b0;
    result.cause           = CAUSE_NONE;

    if (due) begin
      next_check_time_next = seconds_now + TIME_BITS'(check_interval);
      if (cool_over) begin
        result.checked    = 1'b1;
        // Pull the cooldown mark up so it never goes stale across wraps
        cooldown_end_next = seconds_now;

        if (traffic_watch && (idle_time != 16'd0) && in_data.count_ok) begin
          if (!baseline_valid) begin
            baseline_valid_next = 1'b1;
            baseline_count_next = sample;
            baseline_time_next  = seconds_now;
          end else if (idle_window && !idle_trip) begin
            // Traffic grew: advance the baseline
            baseline_count_next = sample;
            baseline_time_next  = seconds_now;
          end
        end

        if (idle_trip) begin
          result.power_cycle     = 1'b1;
          result.cause           = CAUSE_IDLE;
          fail_counter_next      = 8'd0;
          cycles_done_count_next = cycles_done_count + 16'd1;
          cooldown_end_next      = cycle_end;
        end else if (probe_watch) begin
          if (in_data.probe_ok) begin
            fail_counter_next = 8'd0;
          end else if (probe_trip) begin
            result.power_cycle     = 1'b1;
            result.cause           = CAUSE_PROBE;
            fail_counter_next      = 8'd0;
            cycles_done_count_next = cycles_done_count + 16'd1;
            cooldown_end_next      = cycle_end;
          end else begin
            fail_counter_next = fail_bumped;
          end
        end
      end
    end

    result.failures    = fail_counter_next;
    result.cycle_total = cycles_done_count_next;
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      check_interval <= CHECK_INTERVAL_RST;
      fail_limit     <= FAIL_LIMIT_RST;
      cooldown_time  <= COOLDOWN_TIME_RST;
      off_pause      <= OFF_PAUSE_RST;
      idle_time      <= IDLE_TIME_RST;
      scope_sel      <= SCOPE_SEL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CHECK_INTERVAL: check_interval <= cfg_data;
        REG_FAIL_LIMIT:     fail_limit     <= cfg_data[7:0];
        REG_COOLDOWN_TIME:  cooldown_time  <= cfg_data;
        REG_OFF_PAUSE:      off_pause      <= cfg_data[7:0];
        REG_IDLE_TIME:      idle_time      <= cfg_data;
        REG_SCOPE_SEL:      scope_sel      <= scope_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Advance the watchdog state once per tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_now       <= '0;
      next_check_time   <= '0;
      cooldown_end      <= '0;
      fail_counter      <= '0;
      cycles_done_count <= '0;
      baseline_valid    <= 1'b0;
      baseline_count    <= '0;
      baseline_time     <= '0;
    end else if (in_xfer) begin
      seconds_now       <= seconds_now + TIME_BITS'(1);
      next_check_time   <= next_check_time_next;
      cooldown_end      <= cooldown_end_next;
      fail_counter      <= fail_counter_next;
      cycles_done_count <= cycles_done_count_next;
      baseline_valid    <= baseline_valid_next;
      baseline_count    <= baseline_count_next;
      baseline_time     <= baseline_time_next;
    end
  end

  // Result register plus skid: drain the skid first, park a new result
  // there when the result register is held by a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_xfer;
      skid_valid <= 1'b0;
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_xfer) begin
        out_data <= result;
      end
    end else if (in_xfer) begin
      skid_data <= result;
    end
  end

endmodule

FILE: tb/plw_result_checker.sv
`timescale 1ns / 1ps

module plw_result_checker import plw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  tick_in_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  tick_out_t              out_data,
  output int                     mismatch_count,
  output int                     awaited_count
);

  localparam int TIME_W = TIME_BITS_DEF;
  typedef logic [TIME_W-1:0] seconds_t;

  // Register copy, updated from the write port
  logic [15:0] interval_q;
  logic [7:0]  threshold_q;
  logic [15:0] cooldown_q;
  logic [7:0]  pause_q;
  logic [15:0] idle_q;
  scope_t      scope_q;

  // Watchdog state
  seconds_t            now_q;
  seconds_t            next_check_q;
  seconds_t            cooldown_end_q;
  seconds_t            baseline_time_q;
  logic [7:0]          fail_q;
  logic [15:0]         cycles_q;
  logic                baseline_valid_q;
  logic [SAMPLE_W-1:0] baseline_count_q;

  tick_out_t awaited_results[$];
  tick_out_t oldest;

  function automatic logic time_reached(seconds_t now, seconds_t mark);
    seconds_t diff;
    diff = now - mark;
    return !diff[TIME_W-1];
  endfunction

  function automatic void begin_power_cycle(seconds_t now);
    cycles_q = cycles_q + 16'd1;
    fail_q = 8'd0;
    cooldown_end_q = now + pause_q + cooldown_q;
  endfunction

  // Evaluate one tick at the current second, then advance the clock.
  function automatic tick_out_t predict_tick(tick_in_t t);
    tick_out_t r;
    seconds_t  now;
    logic      cycled;
    now = now_q;
    r = '0;
    cycled = 1'b0;
    if (time_reached(now, next_check_q)) begin
      next_check_q = now + interval_q;
      if (time_reached(now, cooldown_end_q)) begin
        r.checked = 1'b1;
        cooldown_end_q = now;
        if (scope_q != SCOPE_PROBE && idle_q != 16'd0 && t.count_ok) begin
          if (!baseline_valid_q) begin
            baseline_valid_q = 1'b1;
            baseline_count_q = t.packet_count;
            baseline_time_q = now;
          end else if ((now - baseline_time_q) >= idle_q) begin
            if (t.packet_count <= baseline_count_q) begin
              begin_power_cycle(now);
              cycled = 1'b1;
              r.cause = CAUSE_IDLE;
            end else begin
              baseline_count_q = t.packet_count;
              baseline_time_q = now;
            end
          end
        end
        if (!cycled && scope_q != SCOPE_TRAFFIC) begin
          if (t.probe_ok) begin
            fail_q = 8'd0;
          end else begin
            if (fail_q != FAIL_MAX) fail_q = fail_q + 8'd1;
            if (fail_q >= threshold_q) begin
              begin_power_cycle(now);
              cycled = 1'b1;
              r.cause = CAUSE_PROBE;
            end
          end
        end
      end
    end
    r.power_cycle = cycled;
    r.failures = fail_q;
    r.cycle_total = cycles_q;
    now_q = now + 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      interval_q = CHECK_INTERVAL_RST;
      threshold_q = FAIL_LIMIT_RST;
      cooldown_q = COOLDOWN_TIME_RST;
      pause_q = OFF_PAUSE_RST;
      idle_q = IDLE_TIME_RST;
      scope_q = SCOPE_SEL_RST;
      now_q = '0;
      next_check_q = '0;
      cooldown_end_q = '0;
      baseline_time_q = '0;
      fail_q = '0;
      cycles_q = '0;
      baseline_valid_q = 1'b0;
      baseline_count_q = '0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("%0t: result with none awaited: checked=%0d power_cycle=%0d",
                     $time, out_data.checked, out_data.power_cycle,
                     " cause=%0d failures=%0d cycle_total=%0d",
                     out_data.cause, out_data.failures, out_data.cycle_total);
        end else begin
          oldest = awaited_results.pop_front();
          if (out_data.checked !== oldest.checked ||
              out_data.power_cycle !== oldest.power_cycle ||
              out_data.cause !== oldest.cause ||
              out_data.failures !== oldest.failures ||
              out_data.cycle_total !== oldest.cycle_total) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected checked=%0d power_cycle=%0d cause=%0d",
                       oldest.checked, oldest.power_cycle, oldest.cause,
                       " failures=%0d cycle_total=%0d",
                       oldest.failures, oldest.cycle_total);
              $display("  actual   checked=%0d power_cycle=%0d cause=%0d",
                       out_data.checked, out_data.power_cycle, out_data.cause,
                       " failures=%0d cycle_total=%0d",
                       out_data.failures, out_data.cycle_total);
            end
          end
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(predict_tick(in_data));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CHECK_INTERVAL: interval_q = cfg_data;
          REG_FAIL_LIMIT:     threshold_q = cfg_data[7:0];
          REG_COOLDOWN_TIME:  cooldown_q = cfg_data;
          REG_OFF_PAUSE:      pause_q = cfg_data[7:0];
          REG_IDLE_TIME:      idle_q = cfg_data;
          REG_SCOPE_SEL:      scope_q = scope_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

FILE: tb/tb_port_liveness_watchdog_unit.sv
`timescale 1ns / 1ps

module tb_port_liveness_watchdog_unit import plw_pkg::*;;

  // Nothing accepted on either channel for this many cycles ends the run.
  localparam int QUIET_LIMIT = 1000;
  // Index outside the register map; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  tick_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  tick_out_t              out_data;

  int mismatch_count;
  int awaited_count;
  int quiet_cycles = 0;

  // Gap modes: when set, the side runs without idling for a stretch.
  logic send_fast = 1'b0;
  logic recv_fast = 1'b0;

  // Running packet counter of the simulated port
  logic [SAMPLE_W-1:0] port_packets = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  port_liveness_watchdog_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  plw_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  // Hang detection: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: hold stall for a drawn number of cycles before each
  // transfer, then wait for the transfer and draw again.
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_fast = !recv_fast;
      hold = recv_fast ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  function automatic tick_in_t make_tick(logic probe, logic cok, logic [SAMPLE_W-1:0] count);
    tick_in_t t;
    t.probe_ok = probe;
    t.count_ok = cok;
    t.packet_count = count;
    return t;
  endfunction

  // Fill bits above the kept width with noise half the time; the block
  // must ignore them.
  function automatic logic [15:0] noisy_high(logic [15:0] v, int kept);
    logic [15:0] mask;
    mask = 16'hFFFF << kept;
    if ($urandom_range(0, 1) == 1) v = v | (16'($urandom) & mask);
    return v;
  endfunction

  // Offer one tick after a drawn gap and hold it until the transfer.
  // Called and returns at a falling edge.
  task automatic send_tick(tick_in_t t);
    int gap;
    if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
    gap = send_fast ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every awaited result has been taken, then
  // let the clock run on idle before returning.
  task automatic settle_port();
    in_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write all registers back to back while the block is idle.
  task automatic apply_settings(logic [15:0] interval, logic [15:0] threshold,
                                logic [15:0] cooldown, logic [15:0] pause,
                                logic [15:0] idle, logic [15:0] scope);
    settle_port();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CHECK_INTERVAL;
    cfg_data <= interval;
    @(negedge clk);
    cfg_index <= REG_FAIL_LIMIT;
    cfg_data <= threshold;
    @(negedge clk);
    cfg_index <= REG_COOLDOWN_TIME;
    cfg_data <= cooldown;
    @(negedge clk);
    cfg_index <= REG_OFF_PAUSE;
    cfg_data <= pause;
    @(negedge clk);
    cfg_index <= REG_IDLE_TIME;
    cfg_data <= idle;
    @(negedge clk);
    cfg_index <= REG_SCOPE_SEL;
    cfg_data <= scope;
    @(negedge clk);
    cfg_index <= UNMAPPED_INDEX;
    cfg_data <= 16'($urandom);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random ticks: the counter mostly stalls or grows, sometimes drops or
  // jumps anywhere, including close to the top of its range.
  task automatic run_traffic_phase(int n_ticks, int fail_pct);
    int r;
    for (int i = 0; i < n_ticks; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        port_packets = port_packets;
      end else if (r < 80) begin
        port_packets = port_packets + $urandom_range(1, 1000);
      end else if (r < 88) begin
        port_packets = port_packets - $urandom_range(1, 1000);
      end else if (r < 94) begin
        port_packets = {16'($urandom), 32'($urandom)};
      end else begin
        port_packets = '1 - $urandom_range(0, 3);
      end
      send_tick(make_tick($urandom_range(0, 99) >= fail_pct,
                          $urandom_range(0, 9) != 0, port_packets));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Reset values: first check is due at second zero, no idle watch.
    send_tick(make_tick(1'b0, 1'b1, '0));
    send_tick(make_tick(1'b0, 1'b0, '1));
    send_tick(make_tick(1'b1, 1'b1, 48'd123));

    // Zero interval, zero threshold, no cooldown, scope three; the check due at second five
    // falls on the third tick: baseline capture, probe trigger on a missing sample, idle trips.
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, {14'd0, SCOPE_ALL});
    send_tick(make_tick(1'b1, 1'b1, '0));
    send_tick(make_tick(1'b1, 1'b1, '1));
    send_tick(make_tick(1'b1, 1'b1, '1));
    send_tick(make_tick(1'b0, 1'b0, '0));
    send_tick(make_tick(1'b0, 1'b1, 48'd5));
    send_tick(make_tick(1'b1, 1'b1, '1));

    // Probe only with a short cooldown: failures accumulate and reset.
    apply_settings(16'd2, 16'd2, 16'd1, 16'd1, 16'd0, {14'd0, SCOPE_PROBE});
    send_tick(make_tick(1'b0, 1'b1, 48'd7));
    send_tick(make_tick(1'b0, 1'b0, 48'd7));
    send_tick(make_tick(1'b0, 1'b1, 48'd7));
    send_tick(make_tick(1'b0, 1'b1, 48'd7));
    send_tick(make_tick(1'b1, 1'b1, 48'd7));
    send_tick(make_tick(1'b0, 1'b1, 48'd7));
    send_tick(make_tick(1'b0, 1'b1, 48'd7));

    // Traffic only: stuck counter, growth, a drop, then no sample.
    apply_settings(16'd1, 16'd1, 16'd0, 16'd2, 16'd3, {14'd0, SCOPE_TRAFFIC});
    repeat (5) send_tick(make_tick(1'b0, 1'b1, 48'd100));
    send_tick(make_tick(1'b0, 1'b1, 48'd200));
    send_tick(make_tick(1'b0, 1'b1, 48'd50));
    send_tick(make_tick(1'b1, 1'b0, 48'd50));

    // Random settings around the interesting small values
    for (int p = 0; p < 7; p++) begin
      apply_settings(16'($urandom_range(0, 12)),
                     noisy_high(16'($urandom_range(0, 6)), 8),
                     16'($urandom_range(0, 20)),
                     noisy_high(16'($urandom_range(0, 5)), 8),
                     ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 15)),
                     noisy_high(16'($urandom_range(0, 3)), 2));
      run_traffic_phase(130, $urandom_range(10, 70));
    end

    // Largest threshold, every probe fails: the count climbs to its top.
    apply_settings(16'd0, 16'd255, 16'd0, 16'd0, 16'd0, {14'd0, SCOPE_PROBE});
    run_traffic_phase(260, 100);

    // Largest interval, cooldown, pause and idle window last, since the
    // long timers they start outlast the rest of the run.
    apply_settings(16'hFFFF, 16'd1, 16'hFFFF, 16'd255, 16'hFFFF, {14'd0, SCOPE_BOTH});
    run_traffic_phase(40, 100);

    settle_port();
    repeat (5) @(negedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
